FILE: design/tagged_response_buffer_assert.svh
// Assertion macros used by the buffer controller.
`ifndef TAGGED_RESPONSE_BUFFER_ASSERT_SVH
`define TAGGED_RESPONSE_BUFFER_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define TRB_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("tagged response buffer: invariant violated");

// A condition that must hold in the cycle where another one holds.
`define TRB_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tagged response buffer: implication violated");

`endif

FILE: design/tbuf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tbuf_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int TAG_W         = 16;
    localparam int PAYLOAD_W     = 64;
    localparam int CMD_W         = 2;
    localparam int STATUS_W      = 3;

    localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REPLY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEND  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_NONE     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FORWARD  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_PUSHED   = 3'd4;

    typedef struct packed {
        logic [TAG_W-1:0]     tag;
        logic [PAYLOAD_W-1:0] payload;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_SHIFT = 3'b100
    } t_state;

endpackage

`default_nettype wire

FILE: design/tbuf_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module tbuf_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire                  i_clk,
    input  wire                  i_we,
    input  wire  [AW-1:0]        i_waddr,
    input  tbuf_pkg::t_entry     i_wdata,
    input  wire  [AW-1:0]        i_raddr,
    output tbuf_pkg::t_entry     o_rdata
);
    import tbuf_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: design/tbuf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "tagged_response_buffer_assert.svh"

module tbuf_ctrl #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int CW    = 5
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              start,
    output logic                             busy,
    input  wire  [tbuf_pkg::CMD_W-1:0]       i_command,
    input  wire  [tbuf_pkg::TAG_W-1:0]       i_tag,
    input  wire  [tbuf_pkg::PAYLOAD_W-1:0]   i_payload,
    input  wire                              i_downstream_empty,
    output logic                             o_we,
    output logic [AW-1:0]                    o_waddr,
    output tbuf_pkg::t_entry                 o_wdata,
    output logic [AW-1:0]                    o_raddr,
    input  tbuf_pkg::t_entry                 i_rdata,
    output logic                             o_valid,
    output logic [tbuf_pkg::STATUS_W-1:0]    o_status,
    output logic [tbuf_pkg::TAG_W-1:0]       o_out_tag,
    output logic [tbuf_pkg::PAYLOAD_W-1:0]   o_out_payload,
    output logic [CW-1:0]                    o_count
);
    import tbuf_pkg::*;

    t_state               r_state, n_state;
    logic [CMD_W-1:0]     r_cmd, n_cmd;
    logic [TAG_W-1:0]     r_tag, n_tag;
    logic                 r_ds, n_ds;
    logic [AW-1:0]        r_idx, n_idx;
    logic [CW-1:0]        r_count, n_count;
    logic [DEPTH-1:0]     r_ready, n_ready;
    logic                 r_valid, n_valid;
    logic [STATUS_W-1:0]  r_status, n_status;
    logic [TAG_W-1:0]     r_out_tag, n_out_tag;
    logic [PAYLOAD_W-1:0] r_out_payload, n_out_payload;

    logic [AW-1:0] s_idx_p1;
    logic [AW-1:0] s_idx_p2;
    logic          s_last;
    logic          s_next_last;
    logic          s_match;

    assign s_idx_p1    = r_idx + AW'(1);
    assign s_idx_p2    = r_idx + AW'(2);
    assign s_last      = ((CW'(r_idx) + CW'(1)) == r_count);
    assign s_next_last = ((CW'(r_idx) + CW'(2)) == r_count);
    assign s_match     = (r_cmd == CMD_REPLY) ? (i_rdata.tag == r_tag) : r_ready[r_idx];

    always_comb begin
        n_state       = r_state;
        n_cmd         = r_cmd;
        n_tag         = r_tag;
        n_ds          = r_ds;
        n_idx         = r_idx;
        n_count       = r_count;
        n_ready       = r_ready;
        n_valid       = 1'b0;
        n_status      = r_status;
        n_out_tag     = r_out_tag;
        n_out_payload = r_out_payload;
        o_we          = 1'b0;
        o_waddr       = r_idx;
        o_wdata       = '{tag: i_tag, payload: i_payload};
        o_raddr       = '0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_out_tag     = '0;
                    n_out_payload = '0;
                    unique case (i_command)
                        CMD_PUSH: begin
                            n_valid = 1'b1;
                            if (r_count == CW'(DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                o_we                       = 1'b1;
                                o_waddr                    = r_count[AW-1:0];
                                n_ready[r_count[AW-1:0]]   = 1'b0;
                                n_count                    = r_count + CW'(1);
                                n_status                   = ST_PUSHED;
                            end
                        end
                        CMD_REPLY, CMD_SEND: begin
                            if (r_count == '0) begin
                                n_valid  = 1'b1;
                                n_status = (i_command == CMD_REPLY) ? ST_NOTFOUND : ST_NONE;
                            end else begin
                                n_cmd   = i_command;
                                n_tag   = i_tag;
                                n_ds    = i_downstream_empty;
                                n_idx   = '0;
                                o_raddr = '0;
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_valid  = 1'b1;
                            n_status = ST_NONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (s_match) begin
                    if (r_ds) begin
                        n_out_tag     = i_rdata.tag;
                        n_out_payload = i_rdata.payload;
                        if (s_last) begin
                            n_count        = r_count - CW'(1);
                            n_ready[r_idx] = 1'b0;
                            n_valid        = 1'b1;
                            n_status       = ST_FORWARD;
                            n_state        = S_IDLE;
                        end else begin
                            o_raddr = s_idx_p1;
                            n_state = S_SHIFT;
                        end
                    end else begin
                        if (r_cmd == CMD_REPLY) begin
                            n_ready[r_idx] = 1'b1;
                        end
                        n_valid  = 1'b1;
                        n_status = ST_NONE;
                        n_state  = S_IDLE;
                    end
                end else if (s_last) begin
                    n_valid  = 1'b1;
                    n_status = (r_cmd == CMD_REPLY) ? ST_NOTFOUND : ST_NONE;
                    n_state  = S_IDLE;
                end else begin
                    n_idx   = s_idx_p1;
                    o_raddr = s_idx_p1;
                end
            end
            S_SHIFT: begin
                o_we           = 1'b1;
                o_waddr        = r_idx;
                o_wdata        = i_rdata;
                n_ready[r_idx] = r_ready[s_idx_p1];
                if (s_next_last) begin
                    n_ready[s_idx_p1] = 1'b0;
                    n_count           = r_count - CW'(1);
                    n_valid           = 1'b1;
                    n_status          = ST_FORWARD;
                    n_state           = S_IDLE;
                end else begin
                    n_idx   = s_idx_p1;
                    o_raddr = s_idx_p2;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ready <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ready <= n_ready;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd         <= n_cmd;
        r_tag         <= n_tag;
        r_ds          <= n_ds;
        r_idx         <= n_idx;
        r_status      <= n_status;
        r_out_tag     <= n_out_tag;
        r_out_payload <= n_out_payload;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_out_tag     = r_out_tag;
    assign o_out_payload = r_out_payload;
    assign o_count       = r_count;

    `TRB_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CW'(DEPTH))
    `TRB_ASSERT_IMPLIES(a_scan_in_range, i_clk, i_rst_n, r_state != S_IDLE,
        CW'(r_idx) < r_count)
    `TRB_ASSERT_IMPLIES(a_push_grows, i_clk, i_rst_n,
        r_valid && (r_status == ST_PUSHED), r_count == $past(r_count) + CW'(1))
    `TRB_ASSERT_IMPLIES(a_forward_shrinks, i_clk, i_rst_n,
        r_valid && (r_status == ST_FORWARD), r_count == $past(r_count) - CW'(1))

endmodule

`default_nettype wire

FILE: design/tagged_response_buffer.sv
// Push, unused command, or reply or send on an empty buffer: busy stays low, the result
// strobe follows in the cycle after the start transfer, and a new transfer can start every cycle.
// Reply or send: busy stays high while one entry is scanned and one younger entry compacted
// per cycle. The strobe follows the last busy cycle, and the next start is taken during the
// strobe. The receiver cannot stall.
// Synchronous reset empties the buffer and clears all ready marks.
`timescale 1ns / 1ps
`default_nettype none

module tagged_response_buffer #(
    parameter int BUFFER_DEPTH = tbuf_pkg::DEPTH_DEFAULT,
    localparam int AW = $clog2(BUFFER_DEPTH),
    localparam int CW = $clog2(BUFFER_DEPTH + 1)
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              start,
    output logic                             busy,
    input  wire  [tbuf_pkg::CMD_W-1:0]       i_command,
    input  wire  [tbuf_pkg::TAG_W-1:0]       i_tag,
    input  wire  [tbuf_pkg::PAYLOAD_W-1:0]   i_payload,
    input  wire                              i_downstream_empty,
    output logic                             o_valid,
    output logic [tbuf_pkg::STATUS_W-1:0]    o_status,
    output logic [tbuf_pkg::TAG_W-1:0]       o_out_tag,
    output logic [tbuf_pkg::PAYLOAD_W-1:0]   o_out_payload,
    output logic [CW-1:0]                    o_occupancy,
    output logic                             o_almost_full,
    output logic                             o_can_start
);
    import tbuf_pkg::*;

    logic          s_we;
    logic [AW-1:0] s_waddr;
    t_entry        s_wdata;
    logic [AW-1:0] s_raddr;
    t_entry        s_rdata;
    logic [CW-1:0] s_count;

    tbuf_mem #(
        .DEPTH (BUFFER_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    tbuf_ctrl #(
        .DEPTH (BUFFER_DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_command          (i_command),
        .i_tag              (i_tag),
        .i_payload          (i_payload),
        .i_downstream_empty (i_downstream_empty),
        .o_we               (s_we),
        .o_waddr            (s_waddr),
        .o_wdata            (s_wdata),
        .o_raddr            (s_raddr),
        .i_rdata            (s_rdata),
        .o_valid            (o_valid),
        .o_status           (o_status),
        .o_out_tag          (o_out_tag),
        .o_out_payload      (o_out_payload),
        .o_count            (s_count)
    );

    assign o_occupancy   = s_count;
    assign o_almost_full = (s_count > CW'(BUFFER_DEPTH - 3));
    assign o_can_start   = ({2'b00, s_count} << 2) <= (CW + 2)'(3 * BUFFER_DEPTH);

endmodule

`default_nettype wire
